### rtl/core/gic_pkg.sv
// ----------------------------------------------------------------------------
// gic_pkg
// Shared widths, register indexes, button positions and interface types of
// the gamepad input conditioner.
// ----------------------------------------------------------------------------
package gic_pkg;

   localparam int SLOT_COUNT      = 8;
   localparam int PAD_INDEX_WIDTH = 3;
   localparam int BUTTON_WIDTH    = 14;
   localparam int RAW_WIDTH       = 8;
   localparam int AXIS_WIDTH      = 16;
   localparam int DEAD_ZONE_WIDTH = 7;
   localparam int WARM_WIDTH      = 3;
   localparam int AXIS_COUNT      = 4;

   localparam int PAD_COUNT_DEFAULT    = 8;
   localparam int WARMUP_READS_DEFAULT = 4;

   localparam int QUOTIENT_WIDTH = 15;
   localparam int DIV_STEPS      = QUOTIENT_WIDTH;
   localparam int DIV_CNT_WIDTH  = $clog2(DIV_STEPS);

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = DEAD_ZONE_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEAD_ZONE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOOK_KEYS = 1'd1;

   localparam logic [DEAD_ZONE_WIDTH-1:0] DEAD_ZONE_RESET = 7'd60;
   localparam logic                       LOOK_KEYS_RESET = 1'b1;

   localparam logic signed [AXIS_WIDTH-1:0] Q_MAX      = 16'sd32767;
   localparam logic signed [AXIS_WIDTH-1:0] IDLE_LIMIT = 16'sd1638;

   localparam int KEY_UP       = 0;
   localparam int KEY_DOWN     = 1;
   localparam int KEY_LEFT     = 2;
   localparam int KEY_RIGHT    = 3;
   localparam int KEY_SQUARE   = 4;
   localparam int KEY_TRIANGLE = 5;
   localparam int KEY_CROSS    = 6;
   localparam int KEY_CIRCLE   = 7;

   // Axis order: left x, left y, right x, right y.
   localparam int   AXIS_NEG_BTN [AXIS_COUNT] = '{KEY_LEFT, KEY_UP, KEY_SQUARE, KEY_TRIANGLE};
   localparam int   AXIS_POS_BTN [AXIS_COUNT] = '{KEY_RIGHT, KEY_DOWN, KEY_CIRCLE, KEY_CROSS};
   localparam logic AXIS_KEYED   [AXIS_COUNT] = '{1'b0, 1'b0, 1'b1, 1'b1};

   typedef struct packed {
      logic [DEAD_ZONE_WIDTH-1:0] dead_zone;
      logic                       look_keys;
   } gic_cfg_type;

   typedef struct packed {
      logic capture;
      logic div_init;
      logic div_step;
      logic commit;
   } gic_cmd_type;

   typedef struct packed {
      logic out_free;
   } gic_stat_type;

endpackage

### rtl/core/gic_csr.sv
// ----------------------------------------------------------------------------
// gic_csr
// Configuration registers: dead zone and look-key enable.
// ----------------------------------------------------------------------------
module gic_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gic_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [gic_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output gic_pkg::gic_cfg_type                 cfg
);

   logic [gic_pkg::DEAD_ZONE_WIDTH-1:0] dead_zone_ff;
   logic                                look_keys_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= gic_pkg::DEAD_ZONE_RESET;
         look_keys_ff <= gic_pkg::LOOK_KEYS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gic_pkg::CSR_DEAD_ZONE: begin
               dead_zone_ff <= csr_data;
            end
            gic_pkg::CSR_LOOK_KEYS: begin
               look_keys_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.dead_zone = dead_zone_ff;
   assign cfg.look_keys = look_keys_ff;

endmodule

### rtl/core/gic_divider.sv
// ----------------------------------------------------------------------------
// gic_divider
// Restoring divider for one axis: one quotient bit per step, giving
// (num * 65536 + den) / (2 * den) with a flag for saturation at 32767.
// ----------------------------------------------------------------------------
module gic_divider (
   input  logic                                  clock,
   input  logic                                  init,
   input  logic                                  step,
   input  logic [gic_pkg::RAW_WIDTH-1:0]         num,
   input  logic [gic_pkg::DEAD_ZONE_WIDTH-1:0]   den,
   output logic [gic_pkg::QUOTIENT_WIDTH-1:0]    quotient,
   output logic                                  saturate
);

   logic [7:0]                              rem_ff, rem_in;
   logic [gic_pkg::QUOTIENT_WIDTH-1:0]      quo_ff, quo_in;
   logic [gic_pkg::QUOTIENT_WIDTH-1:0]      bits_ff, bits_in;
   logic [gic_pkg::DEAD_ZONE_WIDTH-1:0]     den_ff, den_in;
   logic                                    sat_ff, sat_in;
   logic [8:0]                              trial;
   logic [8:0]                              divisor;

   // The quotient stays below 2^15 unless num >= den, so the top of the
   // dividend (2 * num) starts as the partial remainder and the low 15 bits
   // (den itself) are shifted in one per step.
   assign trial   = {rem_ff, bits_ff[gic_pkg::QUOTIENT_WIDTH-1]};
   assign divisor = {1'b0, den_ff, 1'b0};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      bits_in = bits_ff;
      den_in  = den_ff;
      sat_in  = sat_ff;
      if (init) begin
         rem_in  = {num[gic_pkg::RAW_WIDTH-2:0], 1'b0};
         quo_in  = '0;
         bits_in = {{(gic_pkg::QUOTIENT_WIDTH-gic_pkg::DEAD_ZONE_WIDTH){1'b0}}, den};
         den_in  = den;
         sat_in  = (den == '0) || (num >= {1'b0, den});
      end else if (step) begin
         bits_in = {bits_ff[gic_pkg::QUOTIENT_WIDTH-2:0], 1'b0};
         if (trial >= divisor) begin
            rem_in = 8'(trial - divisor);
            quo_in = {quo_ff[gic_pkg::QUOTIENT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[7:0];
            quo_in = {quo_ff[gic_pkg::QUOTIENT_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      bits_ff <= bits_in;
      den_ff  <= den_in;
      sat_ff  <= sat_in;
   end

   assign quotient = quo_ff;
   assign saturate = sat_ff;

endmodule

### rtl/core/gic_ctrl.sv
// ----------------------------------------------------------------------------
// gic_ctrl
// Sequencer: capture a request, run the shared rescale step count, then
// commit state and load the response register.
// ----------------------------------------------------------------------------
module gic_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output gic_pkg::gic_cmd_type  cmd,
   input  gic_pkg::gic_stat_type stat
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_PREP   = 2'd1;
   localparam logic [1:0] S_DIV    = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   localparam logic [gic_pkg::DIV_CNT_WIDTH-1:0] CNT_LAST =
      gic_pkg::DIV_CNT_WIDTH'(gic_pkg::DIV_STEPS - 1);

   logic [1:0]                         state_ff, state_in;
   logic [gic_pkg::DIV_CNT_WIDTH-1:0]  cnt_ff, cnt_in;

   assign req_ready    = (state_ff == S_IDLE);
   assign cmd.capture  = req_valid && req_ready;
   assign cmd.div_init = (state_ff == S_PREP);
   assign cmd.div_step = (state_ff == S_DIV);
   assign cmd.commit   = (state_ff == S_COMMIT) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = S_COMMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_div_ends_in_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == CNT_LAST) |=> (state_ff == S_COMMIT))
      else $error("divide sequence did not end in commit");

   a_capture_then_init: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (cmd.div_init && !req_ready))
      else $error("captured request was not followed by divider setup");

endmodule

### rtl/core/gic_datapath.sv
// ----------------------------------------------------------------------------
// gic_datapath
// Request latch, per-pad state, four rescale lanes, fallback selection and
// the response register.
// ----------------------------------------------------------------------------
module gic_datapath #(
   parameter int PAD_COUNT    = gic_pkg::PAD_COUNT_DEFAULT,
   parameter int WARMUP_READS = gic_pkg::WARMUP_READS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  gic_pkg::gic_cmd_type                        cmd,
   output gic_pkg::gic_stat_type                       stat,
   input  gic_pkg::gic_cfg_type                        cfg,
   input  logic [gic_pkg::PAD_INDEX_WIDTH-1:0]         req_pad_index,
   input  logic                                        req_pad_present,
   input  logic                                        req_new_data,
   input  logic [gic_pkg::BUTTON_WIDTH-1:0]            req_raw_buttons,
   input  logic [gic_pkg::RAW_WIDTH-1:0]               req_left_horizontal,
   input  logic [gic_pkg::RAW_WIDTH-1:0]               req_left_vertical,
   input  logic [gic_pkg::RAW_WIDTH-1:0]               req_right_horizontal,
   input  logic [gic_pkg::RAW_WIDTH-1:0]               req_right_vertical,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [gic_pkg::PAD_INDEX_WIDTH-1:0]         rsp_pad_echo,
   output logic                                        rsp_is_connected,
   output logic [gic_pkg::BUTTON_WIDTH-1:0]            rsp_held_buttons,
   output logic [gic_pkg::BUTTON_WIDTH-1:0]            rsp_pressed_buttons,
   output logic signed [gic_pkg::AXIS_WIDTH-1:0]       rsp_look_left_x,
   output logic signed [gic_pkg::AXIS_WIDTH-1:0]       rsp_look_left_y,
   output logic signed [gic_pkg::AXIS_WIDTH-1:0]       rsp_look_right_x,
   output logic signed [gic_pkg::AXIS_WIDTH-1:0]       rsp_look_right_y
);

   localparam int AW = gic_pkg::AXIS_WIDTH;
   localparam int BW = gic_pkg::BUTTON_WIDTH;
   localparam int RW = gic_pkg::RAW_WIDTH;

   // Latched request.
   logic [gic_pkg::PAD_INDEX_WIDTH-1:0] idx_ff;
   logic                                present_ff;
   logic                                fresh_ff;
   logic [BW-1:0]                       btn_ff;
   logic [RW-1:0]                       raw_ff [gic_pkg::AXIS_COUNT];

   // Per-pad state, and the stick axes of pad 0.
   logic [gic_pkg::WARM_WIDTH-1:0] warm_ff [gic_pkg::SLOT_COUNT];
   logic [BW-1:0]                  cur_ff  [gic_pkg::SLOT_COUNT];
   logic signed [AW-1:0]           axes_ff [gic_pkg::AXIS_COUNT];

   logic                           rsp_valid_ff;
   logic [gic_pkg::PAD_INDEX_WIDTH-1:0] echo_ff;
   logic                           is_conn_ff;
   logic [BW-1:0]                  held_ff;
   logic [BW-1:0]                  pressed_ff;
   logic signed [AW-1:0]           look_ff [gic_pkg::AXIS_COUNT];

   logic [8:0]                          hi;
   logic [8:0]                          lo;
   logic [gic_pkg::DEAD_ZONE_WIDTH-1:0] den;
   logic signed [AW-1:0]                scaled  [gic_pkg::AXIS_COUNT];
   logic signed [AW-1:0]                axes_in [gic_pkg::AXIS_COUNT];
   logic signed [AW-1:0]                look_in [gic_pkg::AXIS_COUNT];

   logic                           idx_ok;
   logic                           idx_zero;
   logic [BW-1:0]                  cur_old;
   logic [gic_pkg::WARM_WIDTH-1:0] warm_old;
   logic [BW-1:0]                  packed_btn;
   logic                           stick_live;
   logic                           conn_in;
   logic [BW-1:0]                  cur_in;
   logic [gic_pkg::WARM_WIDTH-1:0] warm_in;
   logic                           axes_load;
   logic                           axes_clear;
   logic [BW-1:0]                  b0_in;

   assign hi  = 9'd128 + {2'b00, cfg.dead_zone};
   assign lo  = 9'd128 - {2'b00, cfg.dead_zone};
   assign den = gic_pkg::DEAD_ZONE_WIDTH'(7'd127 - cfg.dead_zone);

   for (genvar a = 0; a < gic_pkg::AXIS_COUNT; a++) begin : g_lane
      logic                               pos;
      logic                               neg;
      logic [RW-1:0]                      num;
      logic [gic_pkg::QUOTIENT_WIDTH-1:0] quo;
      logic                               sat;
      logic signed [AW-1:0]               mag;
      logic signed [AW-1:0]               val;
      logic signed [AW-1:0]               val_abs;
      logic                               en;
      logic signed [AW-1:0]               key_val;

      assign pos = {1'b0, raw_ff[a]} > hi;
      assign neg = {1'b0, raw_ff[a]} < lo;
      assign num = pos ? RW'({1'b0, raw_ff[a]} - hi) : RW'(lo - {1'b0, raw_ff[a]});

      gic_divider u_div (
         .clock    (clock),
         .init     (cmd.div_init),
         .step     (cmd.div_step),
         .num      (num),
         .den      (den),
         .quotient (quo),
         .saturate (sat)
      );

      assign mag       = sat ? gic_pkg::Q_MAX : {1'b0, quo};
      assign scaled[a] = !(pos || neg) ? '0 : (neg ? -mag : mag);

      assign axes_in[a] = axes_clear ? '0 : (axes_load ? scaled[a] : axes_ff[a]);

      assign val     = axes_in[a];
      assign val_abs = (val < 0) ? -val : val;
      assign en      = !gic_pkg::AXIS_KEYED[a] || cfg.look_keys;

      always_comb begin
         key_val = '0;
         if (en) begin
            if (b0_in[gic_pkg::AXIS_NEG_BTN[a]]) begin
               key_val = -gic_pkg::Q_MAX;
            end
            if (b0_in[gic_pkg::AXIS_POS_BTN[a]]) begin
               key_val = gic_pkg::Q_MAX;
            end
         end
      end

      assign look_in[a] = (val_abs > gic_pkg::IDLE_LIMIT) ? val : key_val;
   end

   always_comb begin
      idx_ok   = 32'(idx_ff) < PAD_COUNT;
      idx_zero = idx_ok && (idx_ff == '0);
      cur_old  = cur_ff[idx_ff];
      warm_old = warm_ff[idx_ff];

      stick_live = !(raw_ff[0] == '0 && raw_ff[1] == '0);
      packed_btn = btn_ff;
      if (stick_live && ({1'b0, raw_ff[1]} < lo)) begin
         packed_btn[gic_pkg::KEY_UP] = 1'b1;
      end
      if (stick_live && ({1'b0, raw_ff[1]} > hi)) begin
         packed_btn[gic_pkg::KEY_DOWN] = 1'b1;
      end

      conn_in    = 1'b0;
      cur_in     = cur_old;
      warm_in    = warm_old;
      axes_load  = 1'b0;
      axes_clear = 1'b0;
      if (!present_ff) begin
         cur_in     = '0;
         warm_in    = '0;
         axes_clear = idx_zero;
      end else begin
         conn_in = 1'b1;
         if (fresh_ff) begin
            if (warm_old < gic_pkg::WARM_WIDTH'(WARMUP_READS)) begin
               warm_in = warm_old + 1'b1;
            end else begin
               cur_in    = packed_btn;
               axes_load = idx_zero;
            end
         end
      end

      b0_in = idx_zero ? cur_in : cur_ff[0];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff     <= req_pad_index;
         present_ff <= req_pad_present;
         fresh_ff   <= req_new_data;
         btn_ff     <= req_raw_buttons;
         raw_ff[0]  <= req_left_horizontal;
         raw_ff[1]  <= req_left_vertical;
         raw_ff[2]  <= req_right_horizontal;
         raw_ff[3]  <= req_right_vertical;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gic_pkg::SLOT_COUNT; i++) begin
            warm_ff[i] <= '0;
            cur_ff[i]  <= '0;
         end
         for (int a = 0; a < gic_pkg::AXIS_COUNT; a++) begin
            axes_ff[a] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            if (idx_ok) begin
               cur_ff[idx_ff]  <= cur_in;
               warm_ff[idx_ff] <= warm_in;
            end
            for (int a = 0; a < gic_pkg::AXIS_COUNT; a++) begin
               axes_ff[a] <= axes_in[a];
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         echo_ff    <= idx_ff;
         is_conn_ff <= idx_ok && conn_in;
         held_ff    <= idx_ok ? cur_in : '0;
         pressed_ff <= idx_ok ? (cur_in & ~cur_old) : '0;
         for (int a = 0; a < gic_pkg::AXIS_COUNT; a++) begin
            look_ff[a] <= look_in[a];
         end
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pad_echo        = echo_ff;
   assign rsp_is_connected    = is_conn_ff;
   assign rsp_held_buttons    = held_ff;
   assign rsp_pressed_buttons = pressed_ff;
   assign rsp_look_left_x     = look_ff[0];
   assign rsp_look_left_y     = look_ff[1];
   assign rsp_look_right_x    = look_ff[2];
   assign rsp_look_right_y    = look_ff[3];

   a_pressed_in_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((pressed_ff & ~held_ff) == '0))
      else $error("pressed buttons not contained in held buttons");

   a_disconnected_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !is_conn_ff) |-> (held_ff == '0))
      else $error("disconnected pad reports held buttons");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (look_ff[0] != 16'sh8000 && look_ff[1] != 16'sh8000 &&
                        look_ff[2] != 16'sh8000 && look_ff[3] != 16'sh8000))
      else $error("look axis outside symmetric Q15 range");

endmodule

### rtl/core/gamepad_input_conditioner_unit.sv
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_unit
// Per-pad button packing, press-edge detection and dead-zone rescaling of
// pad 0's sticks to Q15, with D-pad and face-key fallback for idle axes.
//
//   Channel   Direction  Handshake              Contents
//   req_      in         req_valid/req_ready    one controller report
//   rsp_      out        rsp_valid/rsp_ready    held, pressed, look axes
//   csr_      in         csr_valid/csr_ready    dead_zone, look_keys
//
// After a request is accepted, the controller sets up the dividers, runs the
// bit-per-cycle restoring dividers of the four axis lanes, then commits. The
// next request is accepted only once the commit is done, so requests are
// handled one at a time. A response waiting on rsp_ready does not block the
// next request; only its commit waits for the response register.
// Reset clears all pad state and restores the configuration defaults.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner_unit #(
   parameter int PAD_COUNT    = gic_pkg::PAD_COUNT_DEFAULT,
   parameter int WARMUP_READS = gic_pkg::WARMUP_READS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [gic_pkg::PAD_INDEX_WIDTH-1:0]         req_pad_index,
   input  logic                                        req_pad_present,
   input  logic                                        req_new_data,
   input  logic [gic_pkg::BUTTON_WIDTH-1:0]            req_raw_buttons,
   input  logic [gic_pkg::RAW_WIDTH-1:0]               req_left_horizontal,
   input  logic [gic_pkg::RAW_WIDTH-1:0]               req_left_vertical,
   input  logic [gic_pkg::RAW_WIDTH-1:0]               req_right_horizontal,
   input  logic [gic_pkg::RAW_WIDTH-1:0]               req_right_vertical,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [gic_pkg::PAD_INDEX_WIDTH-1:0]         rsp_pad_echo,
   output logic                                        rsp_is_connected,
   output logic [gic_pkg::BUTTON_WIDTH-1:0]            rsp_held_buttons,
   output logic [gic_pkg::BUTTON_WIDTH-1:0]            rsp_pressed_buttons,
   output logic signed [gic_pkg::AXIS_WIDTH-1:0]       rsp_look_left_x,
   output logic signed [gic_pkg::AXIS_WIDTH-1:0]       rsp_look_left_y,
   output logic signed [gic_pkg::AXIS_WIDTH-1:0]       rsp_look_right_x,
   output logic signed [gic_pkg::AXIS_WIDTH-1:0]       rsp_look_right_y,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [gic_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  logic [gic_pkg::CSR_DATA_WIDTH-1:0]          csr_data
);

   gic_pkg::gic_cfg_type  cfg;
   gic_pkg::gic_cmd_type  cmd;
   gic_pkg::gic_stat_type stat;

   gic_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   gic_datapath #(
      .PAD_COUNT    (PAD_COUNT),
      .WARMUP_READS (WARMUP_READS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .cfg                  (cfg),
      .req_pad_index        (req_pad_index),
      .req_pad_present      (req_pad_present),
      .req_new_data         (req_new_data),
      .req_raw_buttons      (req_raw_buttons),
      .req_left_horizontal  (req_left_horizontal),
      .req_left_vertical    (req_left_vertical),
      .req_right_horizontal (req_right_horizontal),
      .req_right_vertical   (req_right_vertical),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pad_echo         (rsp_pad_echo),
      .rsp_is_connected     (rsp_is_connected),
      .rsp_held_buttons     (rsp_held_buttons),
      .rsp_pressed_buttons  (rsp_pressed_buttons),
      .rsp_look_left_x      (rsp_look_left_x),
      .rsp_look_left_y      (rsp_look_left_y),
      .rsp_look_right_x     (rsp_look_right_x),
      .rsp_look_right_y     (rsp_look_right_y)
   );

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives controller reports into the gamepad input conditioner and checks
// every response against a cycle-free model of the pad state, the dead-zone
// rescaling and the D-pad and face-key fallback. The run covers several
// dead-zone and look-key settings, random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PADS        = gic_pkg::PAD_COUNT_DEFAULT;
   localparam int WARMUP      = gic_pkg::WARMUP_READS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      bit [gic_pkg::PAD_INDEX_WIDTH-1:0] pad;
      bit                                present;
      bit                                fresh;
      bit [gic_pkg::BUTTON_WIDTH-1:0]    raw;
      bit [gic_pkg::RAW_WIDTH-1:0]       lh;
      bit [gic_pkg::RAW_WIDTH-1:0]       lv;
      bit [gic_pkg::RAW_WIDTH-1:0]       rh;
      bit [gic_pkg::RAW_WIDTH-1:0]       rv;
   } pad_report_type;

   typedef struct {
      bit [gic_pkg::PAD_INDEX_WIDTH-1:0] pad;
      bit                                conn;
      bit [gic_pkg::BUTTON_WIDTH-1:0]    held;
      bit [gic_pkg::BUTTON_WIDTH-1:0]    pressed;
      int                                lx;
      int                                ly;
      int                                rx;
      int                                ry;
   } pad_frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [gic_pkg::PAD_INDEX_WIDTH-1:0]  req_pad_index = '0;
   logic                                 req_pad_present = 1'b0;
   logic                                 req_new_data = 1'b0;
   logic [gic_pkg::BUTTON_WIDTH-1:0]     req_raw_buttons = '0;
   logic [gic_pkg::RAW_WIDTH-1:0]        req_left_horizontal = '0;
   logic [gic_pkg::RAW_WIDTH-1:0]        req_left_vertical = '0;
   logic [gic_pkg::RAW_WIDTH-1:0]        req_right_horizontal = '0;
   logic [gic_pkg::RAW_WIDTH-1:0]        req_right_vertical = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [gic_pkg::PAD_INDEX_WIDTH-1:0]  rsp_pad_echo;
   logic                                 rsp_is_connected;
   logic [gic_pkg::BUTTON_WIDTH-1:0]     rsp_held_buttons;
   logic [gic_pkg::BUTTON_WIDTH-1:0]     rsp_pressed_buttons;
   logic signed [gic_pkg::AXIS_WIDTH-1:0] rsp_look_left_x;
   logic signed [gic_pkg::AXIS_WIDTH-1:0] rsp_look_left_y;
   logic signed [gic_pkg::AXIS_WIDTH-1:0] rsp_look_right_x;
   logic signed [gic_pkg::AXIS_WIDTH-1:0] rsp_look_right_y;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [gic_pkg::CSR_INDEX_WIDTH-1:0]  csr_index = '0;
   logic [gic_pkg::CSR_DATA_WIDTH-1:0]   csr_data = '0;

   gamepad_input_conditioner_unit #(
      .PAD_COUNT(PADS),
      .WARMUP_READS(WARMUP)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pad_index(req_pad_index),
      .req_pad_present(req_pad_present),
      .req_new_data(req_new_data),
      .req_raw_buttons(req_raw_buttons),
      .req_left_horizontal(req_left_horizontal),
      .req_left_vertical(req_left_vertical),
      .req_right_horizontal(req_right_horizontal),
      .req_right_vertical(req_right_vertical),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pad_echo(rsp_pad_echo),
      .rsp_is_connected(rsp_is_connected),
      .rsp_held_buttons(rsp_held_buttons),
      .rsp_pressed_buttons(rsp_pressed_buttons),
      .rsp_look_left_x(rsp_look_left_x),
      .rsp_look_left_y(rsp_look_left_y),
      .rsp_look_right_x(rsp_look_right_x),
      .rsp_look_right_y(rsp_look_right_y),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // Model state of the conditioner.
   int                             cfg_dead_zone = int'(gic_pkg::DEAD_ZONE_RESET);
   bit                             cfg_look_keys = gic_pkg::LOOK_KEYS_RESET;
   bit [gic_pkg::WARM_WIDTH-1:0]   warm_reads [gic_pkg::SLOT_COUNT];
   bit [gic_pkg::BUTTON_WIDTH-1:0] held_keys [gic_pkg::SLOT_COUNT];
   bit [gic_pkg::BUTTON_WIDTH-1:0] prev_keys [gic_pkg::SLOT_COUNT];
   bit                             pad_linked [gic_pkg::SLOT_COUNT];
   int                             stick_q15 [gic_pkg::AXIS_COUNT];

   pad_report_type pending_reports[$];
   pad_frame_type  expected_frames[$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  sent_total = 0;
   int  rsp_count = 0;
   bit  req_taken = 1'b0;
   bit  rsp_taken = 1'b0;
   bit  csr_taken = 1'b0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   bit  req_burst = 1'b0;
   bit  rsp_burst = 1'b0;

   function automatic bit [gic_pkg::BUTTON_WIDTH-1:0] pack_keys(
      bit [gic_pkg::BUTTON_WIDTH-1:0] raw, bit [gic_pkg::RAW_WIDTH-1:0] lh,
      bit [gic_pkg::RAW_WIDTH-1:0] lv);
      bit [gic_pkg::BUTTON_WIDTH-1:0] b;
      b = raw;
      if (!(lh == 0 && lv == 0)) begin
         if (int'(lv) < 128 - cfg_dead_zone) b[gic_pkg::KEY_UP] = 1'b1;
         if (int'(lv) > 128 + cfg_dead_zone) b[gic_pkg::KEY_DOWN] = 1'b1;
      end
      return b;
   endfunction

   function automatic int dz_rescale(bit [gic_pkg::RAW_WIDTH-1:0] raw);
      int d;
      int den;
      int num;
      int q;
      bit neg;
      d = int'(raw) - 128;
      den = 127 - cfg_dead_zone;
      if (d > cfg_dead_zone) begin
         num = d - cfg_dead_zone;
         neg = 1'b0;
      end else if (d < -cfg_dead_zone) begin
         num = -d - cfg_dead_zone;
         neg = 1'b1;
      end else begin
         return 0;
      end
      if (den <= 0) begin
         q = int'(gic_pkg::Q_MAX);
      end else begin
         q = (num * 65536 + den) / (2 * den);
         if (q > int'(gic_pkg::Q_MAX)) q = int'(gic_pkg::Q_MAX);
      end
      return neg ? -q : q;
   endfunction

   function automatic int pick_look(int a, bit [gic_pkg::BUTTON_WIDTH-1:0] b, int neg_btn,
                                    int pos_btn, bit enabled);
      int d;
      int mag;
      d = 0;
      mag = (a < 0) ? -a : a;
      if (enabled) begin
         if (b[neg_btn]) d = -int'(gic_pkg::Q_MAX);
         if (b[pos_btn]) d = int'(gic_pkg::Q_MAX);
      end
      return (mag > int'(gic_pkg::IDLE_LIMIT)) ? a : d;
   endfunction

   function automatic pad_frame_type condition_report(pad_report_type r);
      pad_frame_type f;
      bit [gic_pkg::BUTTON_WIDTH-1:0] b0;
      f = '{default: 0};
      f.pad = r.pad;
      if (int'(r.pad) < PADS) begin
         prev_keys[r.pad] = held_keys[r.pad];
         if (!r.present) begin
            pad_linked[r.pad] = 1'b0;
            held_keys[r.pad] = '0;
            warm_reads[r.pad] = '0;
            if (r.pad == 0) stick_q15 = '{0, 0, 0, 0};
         end else begin
            pad_linked[r.pad] = 1'b1;
            if (r.fresh) begin
               if (int'(warm_reads[r.pad]) < WARMUP) begin
                  warm_reads[r.pad] = warm_reads[r.pad] + 1'b1;
               end else begin
                  held_keys[r.pad] = pack_keys(r.raw, r.lh, r.lv);
                  if (r.pad == 0) begin
                     stick_q15[0] = dz_rescale(r.lh);
                     stick_q15[1] = dz_rescale(r.lv);
                     stick_q15[2] = dz_rescale(r.rh);
                     stick_q15[3] = dz_rescale(r.rv);
                  end
               end
            end
         end
         f.conn = pad_linked[r.pad];
         f.held = held_keys[r.pad];
         f.pressed = held_keys[r.pad] & ~prev_keys[r.pad];
      end
      b0 = held_keys[0];
      f.lx = pick_look(stick_q15[0], b0, gic_pkg::KEY_LEFT, gic_pkg::KEY_RIGHT, 1'b1);
      f.ly = pick_look(stick_q15[1], b0, gic_pkg::KEY_UP, gic_pkg::KEY_DOWN, 1'b1);
      f.rx = pick_look(stick_q15[2], b0, gic_pkg::KEY_SQUARE, gic_pkg::KEY_CIRCLE,
                       cfg_look_keys);
      f.ry = pick_look(stick_q15[3], b0, gic_pkg::KEY_TRIANGLE, gic_pkg::KEY_CROSS,
                       cfg_look_keys);
      return f;
   endfunction

   task automatic check_field(string name, int expected_value, int actual_value);
      if (expected_value != actual_value) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                  expected_value, actual_value);
      end
   endtask

   // Response checking, handshake sampling and the cycle limit.
   always @(posedge clock) begin
      pad_frame_type e;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         req_taken = req_valid && req_ready && !reset;
         rsp_taken = rsp_valid && rsp_ready && !reset;
         csr_taken = csr_valid && csr_ready && !reset;
         if (csr_taken) begin
            if (csr_index == gic_pkg::CSR_DEAD_ZONE) cfg_dead_zone = int'(csr_data);
            else if (csr_index == gic_pkg::CSR_LOOK_KEYS) cfg_look_keys = csr_data[0];
         end
         if (req_taken) begin
            expected_frames.push_back(condition_report('{req_pad_index, req_pad_present,
               req_new_data, req_raw_buttons, req_left_horizontal, req_left_vertical,
               req_right_horizontal, req_right_vertical}));
         end
         if (rsp_taken) begin
            rsp_count++;
            if (expected_frames.size() == 0) begin
               error_count++;
               $display("%0t: response with no request pending, pad %0d", $time,
                        rsp_pad_echo);
            end else begin
               e = expected_frames.pop_front();
               check_field("pad_echo", e.pad, rsp_pad_echo);
               check_field("is_connected", e.conn, rsp_is_connected);
               check_field("held_buttons", e.held, rsp_held_buttons);
               check_field("pressed_buttons", e.pressed, rsp_pressed_buttons);
               check_field("look_left_x", e.lx, rsp_look_left_x);
               check_field("look_left_y", e.ly, rsp_look_left_y);
               check_field("look_right_x", e.rx, rsp_look_right_x);
               check_field("look_right_y", e.ry, rsp_look_right_y);
            end
         end
      end
   end

   // Request driver.
   always @(negedge clock) begin
      pad_report_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_reports.size() != 0) begin
            r = pending_reports.pop_front();
            req_pad_index <= r.pad;
            req_pad_present <= r.present;
            req_new_data <= r.fresh;
            req_raw_buttons <= r.raw;
            req_left_horizontal <= r.lh;
            req_left_vertical <= r.lv;
            req_right_horizontal <= r.rh;
            req_right_vertical <= r.rv;
            req_valid <= 1'b1;
            if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
            req_gap = req_burst ? 0 : $urandom_range(0, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall driver.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 13);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic push_report(int pad, bit present, bit fresh, int raw,
                              int lh, int lv, int rh, int rv);
      pending_reports.push_back('{gic_pkg::PAD_INDEX_WIDTH'(pad), present, fresh,
                                  gic_pkg::BUTTON_WIDTH'(raw), gic_pkg::RAW_WIDTH'(lh),
                                  gic_pkg::RAW_WIDTH'(lv), gic_pkg::RAW_WIDTH'(rh),
                                  gic_pkg::RAW_WIDTH'(rv)});
      sent_total++;
   endtask

   function automatic bit [gic_pkg::RAW_WIDTH-1:0] rand_stick();
      int v;
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(253, 255);
         1: v = 128 + $urandom_range(0, 8) - 4;
         2: v = 128 + cfg_dead_zone + $urandom_range(0, 3) - 1;
         3: v = 128 - cfg_dead_zone - $urandom_range(0, 3) + 1;
         4: v = 128;
         default: v = $urandom_range(0, 255);
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[gic_pkg::RAW_WIDTH-1:0];
   endfunction

   task automatic push_random(int count);
      int pad;
      int raw;
      int lh;
      int lv;
      repeat (count) begin
         pad = $urandom_range(0, 1) ? 0 : $urandom_range(1, PADS - 1);
         case ($urandom_range(0, 3))
            0: raw = 0;
            1: raw = 1 << $urandom_range(0, gic_pkg::BUTTON_WIDTH - 1);
            2: raw = $urandom_range(0, 255);
            default: raw = $urandom_range(0, (1 << gic_pkg::BUTTON_WIDTH) - 1);
         endcase
         lh = rand_stick();
         lv = rand_stick();
         if ($urandom_range(0, 19) == 0) begin
            lh = 0;
            lv = 0;
         end
         push_report(pad, $urandom_range(0, 24) != 0, $urandom_range(0, 9) != 0, raw,
                     lh, lv, rand_stick(), rand_stick());
      end
   endtask

   task automatic wait_drained();
      while (rsp_count != sent_total) @(negedge clock);
   endtask

   task automatic write_csr(logic [gic_pkg::CSR_INDEX_WIDTH-1:0] index, int value);
      @(negedge clock);
      csr_index <= index;
      csr_data <= value[gic_pkg::CSR_DATA_WIDTH-1:0];
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   initial begin
      foreach (warm_reads[i]) begin
         warm_reads[i] = '0;
         held_keys[i] = '0;
         prev_keys[i] = '0;
         pad_linked[i] = 1'b0;
      end
      stick_q15 = '{0, 0, 0, 0};
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      repeat (WARMUP) push_report(0, 1, 1, 16'h3FFF, 255, 0, 255, 0);
      push_report(0, 1, 1, 16'h3FFF, 255, 0, 255, 0);
      push_report(0, 1, 1, 0, 0, 0, 128, 128);
      push_report(0, 1, 1, 16'h00FF, 128, 128, 128, 128);
      push_report(0, 1, 1, (1 << gic_pkg::KEY_LEFT) | (1 << gic_pkg::KEY_UP)
                  | (1 << gic_pkg::KEY_SQUARE) | (1 << gic_pkg::KEY_TRIANGLE),
                  128, 128, 128, 128);
      push_report(0, 1, 0, 0, 1, 254, 188, 68);
      push_report(0, 1, 1, 0, 1, 254, 188, 68);
      push_report(0, 1, 1, 16'h3F00, 188, 189, 187, 67);
      push_report(0, 0, 1, 16'h3FFF, 255, 255, 255, 255);
      repeat (WARMUP + 1) push_report(7, 1, 1, 16'h3FFF, 0, 255, 0, 255);
      push_report(7, 1, 1, 16'h2AAA, 128, 128, 128, 128);
      push_report(7, 1, 1, 16'h1555, 128, 128, 128, 128);
      push_report(7, 0, 0, 0, 0, 0, 0, 0);
      push_report(3, 1, 0, 16'h3FFF, 128, 128, 128, 128);
      push_random(150);
      wait_drained();

      write_csr(gic_pkg::CSR_DEAD_ZONE, 0);
      write_csr(gic_pkg::CSR_LOOK_KEYS, 0);
      repeat (WARMUP + 1) push_report(0, 1, 1, 16'h00F0, 129, 127, 128, 255);
      push_random(150);
      wait_drained();

      write_csr(gic_pkg::CSR_DEAD_ZONE, 126);
      write_csr(gic_pkg::CSR_LOOK_KEYS, 1);
      repeat (WARMUP + 1) push_report(0, 1, 1, 16'h0080, 255, 0, 1, 254);
      push_random(120);
      wait_drained();

      write_csr(gic_pkg::CSR_DEAD_ZONE, 127);
      repeat (WARMUP + 1) push_report(0, 1, 1, 0, 0, 255, 0, 255);
      push_report(0, 1, 1, 16'h00A5, 255, 1, 128, 0);
      push_random(100);
      wait_drained();

      write_csr(gic_pkg::CSR_DEAD_ZONE, $urandom_range(1, 125));
      write_csr(gic_pkg::CSR_LOOK_KEYS, 0);
      push_random(130);
      wait_drained();

      write_csr(gic_pkg::CSR_DEAD_ZONE, int'(gic_pkg::DEAD_ZONE_RESET));
      write_csr(gic_pkg::CSR_LOOK_KEYS, 1);
      push_random(150);
      wait_drained();

      repeat (24) @(negedge clock);
      if (expected_frames.size() != 0) begin
         error_count++;
         $display("%0t: %0d responses never arrived", $time, expected_frames.size());
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/gic_pkg.sv
rtl/core/gic_csr.sv
rtl/core/gic_divider.sv
rtl/core/gic_ctrl.sv
rtl/core/gic_datapath.sv
rtl/core/gamepad_input_conditioner_unit.sv
dv/tb_top.sv
